// ===== rtl/vamc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vamc_pkg
// Shared widths and types for the velocity accumulate / magnitude clamp unit.
// ----------------------------------------------------------------------------
package vamc_pkg;

    localparam int DATA_W  = 16;   // velocity component, signed
    localparam int SUM_W   = 17;   // internal accumulated component
    localparam int LIMIT_W = 15;   // speed limit, unsigned
    localparam int SQ_W    = 34;   // x*x + y*y
    localparam int ROOT_W  = 17;   // floor sqrt of SQ_W value

    typedef struct packed {
        logic signed [DATA_W-1:0] speed_x;
        logic signed [DATA_W-1:0] speed_y;
        logic                     was_limited;
    } vamc_result_t;

    typedef struct packed {
        logic idle;
        logic done;
    } vamc_status_t;

endpackage

// ===== rtl/vamc_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vamc_req_if
// Input channel: one velocity adjustment pair per beat.
// ----------------------------------------------------------------------------
interface vamc_req_if;
    logic                              valid;
    logic                              ready;
    logic signed [vamc_pkg::DATA_W-1:0] delta_x;
    logic signed [vamc_pkg::DATA_W-1:0] delta_y;

    modport source (output valid, output delta_x, output delta_y, input ready);
    modport sink   (input valid, input delta_x, input delta_y, output ready);
endinterface

// ===== rtl/vamc_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vamc_rsp_if
// Output channel: new velocity vector and clamp flag per beat.
// ----------------------------------------------------------------------------
interface vamc_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [vamc_pkg::DATA_W-1:0] speed_x;
    logic signed [vamc_pkg::DATA_W-1:0] speed_y;
    logic                              was_limited;

    modport source (output valid, output speed_x, output speed_y, output was_limited,
                    input ready);
    modport sink   (input valid, input speed_x, input speed_y, input was_limited,
                    output ready);
endinterface

// ===== rtl/vamc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vamc_core
// Sequencer around one shared 17x17 multiplier, a radix-2 square root step
// and a restoring divide step. Holds the velocity state.
// ----------------------------------------------------------------------------
module vamc_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [vamc_pkg::DATA_W-1:0]  delta_x,
    input  logic signed [vamc_pkg::DATA_W-1:0]  delta_y,
    input  logic        [vamc_pkg::LIMIT_W-1:0] speed_limit,
    input  logic                                out_free,
    output vamc_pkg::vamc_status_t              status,
    output vamc_pkg::vamc_result_t              result
);

    localparam int SUM_W   = vamc_pkg::SUM_W;
    localparam int DATA_W  = vamc_pkg::DATA_W;
    localparam int LIMIT_W = vamc_pkg::LIMIT_W;
    localparam int SQ_W    = vamc_pkg::SQ_W;
    localparam int ROOT_W  = vamc_pkg::ROOT_W;
    localparam int REM_W   = ROOT_W + 1;
    localparam int CNT_W   = 5;
    localparam logic [CNT_W-1:0] RootLast = CNT_W'(ROOT_W - 1);
    localparam logic [CNT_W-1:0] DivLast  = CNT_W'(LIMIT_W - 1);

    typedef enum logic [2:0] {
        IDLE,
        SQ_X,
        SQ_Y,
        SUM,
        ROOT,
        CHECK,
        SCALE_MUL,
        SCALE_DIV
    } state_t;

    state_t                    state_reg;
    logic                      finish_reg;
    logic signed [SUM_W-1:0]   sx_reg, sy_reg;
    logic signed [DATA_W-1:0]  held_x_reg, held_y_reg;
    logic        [SQ_W-1:0]    rad_reg, prod_reg;
    logic        [REM_W-1:0]   rem_reg;
    logic        [ROOT_W-1:0]  root_reg;
    logic        [CNT_W-1:0]   cnt_reg;
    logic                      sel_y_reg;
    logic        [SUM_W-1:0]   drem_reg;
    logic        [LIMIT_W-1:0] dbits_reg;
    logic                      limited_reg;
    logic signed [DATA_W-1:0]  res_x_reg, res_y_reg;

    logic [SUM_W-1:0]   ax, ay, mul_a, mul_b;
    logic [SQ_W-1:0]    product;
    logic [REM_W+1:0]   rem_sh, trial;
    logic               root_bit;
    logic [SUM_W:0]     dsh;
    logic               quot_bit;
    logic [LIMIT_W-1:0] quot_next;
    logic               comp_neg;
    logic [DATA_W-1:0]  quot_mag, quot_signed;

    assign ax = sx_reg[SUM_W-1] ? (~sx_reg + 1'b1) : sx_reg;
    assign ay = sy_reg[SUM_W-1] ? (~sy_reg + 1'b1) : sy_reg;

    always_comb
    begin
        mul_a = ax;
        mul_b = ax;
        unique case (state_reg)
            SQ_Y:
            begin
                mul_a = ay;
                mul_b = ay;
            end
            SCALE_MUL:
            begin
                mul_a = sel_y_reg ? ay : ax;
                mul_b = {{(SUM_W-LIMIT_W){1'b0}}, speed_limit};
            end
            default:
            begin
                mul_a = ax;
                mul_b = ax;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // square root step: two radicand bits in, one root bit out
    assign rem_sh   = {rem_reg, rad_reg[SQ_W-1 -: 2]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign root_bit = (rem_sh >= trial);

    // divide step: one quotient bit per cycle
    assign dsh       = {drem_reg, dbits_reg[LIMIT_W-1]};
    assign quot_bit  = (dsh >= {1'b0, root_reg});
    assign quot_next = {dbits_reg[LIMIT_W-2:0], quot_bit};
    assign comp_neg  = sel_y_reg ? sy_reg[SUM_W-1] : sx_reg[SUM_W-1];
    assign quot_mag  = {{(DATA_W-LIMIT_W){1'b0}}, quot_next};
    assign quot_signed = comp_neg ? (~quot_mag + 1'b1) : quot_mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= IDLE;
            finish_reg  <= 1'b0;
            held_x_reg  <= '0;
            held_y_reg  <= '0;
            cnt_reg     <= '0;
            sel_y_reg   <= 1'b0;
            limited_reg <= 1'b0;
        end
        else
        begin
            if (finish_reg)
            begin
                if (out_free)
                begin
                    finish_reg <= 1'b0;
                    held_x_reg <= res_x_reg;
                    held_y_reg <= res_y_reg;
                end
            end
            else
            begin
                unique case (state_reg)
                    IDLE:
                    begin
                        if (start)
                        begin
                            sx_reg    <= {held_x_reg[DATA_W-1], held_x_reg}
                                       + {delta_x[DATA_W-1], delta_x};
                            sy_reg    <= {held_y_reg[DATA_W-1], held_y_reg}
                                       + {delta_y[DATA_W-1], delta_y};
                            state_reg <= SQ_X;
                        end
                    end
                    SQ_X:
                    begin
                        rad_reg   <= product;
                        state_reg <= SQ_Y;
                    end
                    SQ_Y:
                    begin
                        prod_reg  <= product;
                        state_reg <= SUM;
                    end
                    SUM:
                    begin
                        rad_reg   <= rad_reg + prod_reg;
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= RootLast;
                        state_reg <= ROOT;
                    end
                    ROOT:
                    begin
                        rem_reg  <= root_bit ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
                        root_reg <= {root_reg[ROOT_W-2:0], root_bit};
                        rad_reg  <= {rad_reg[SQ_W-3:0], 2'b00};
                        cnt_reg  <= cnt_reg - 1'b1;
                        if (cnt_reg == '0)
                        begin
                            state_reg <= CHECK;
                        end
                    end
                    CHECK:
                    begin
                        if (root_reg > {{(ROOT_W-LIMIT_W){1'b0}}, speed_limit})
                        begin
                            limited_reg <= 1'b1;
                            sel_y_reg   <= 1'b0;
                            state_reg   <= SCALE_MUL;
                        end
                        else
                        begin
                            limited_reg <= 1'b0;
                            res_x_reg   <= sx_reg[DATA_W-1:0];
                            res_y_reg   <= sy_reg[DATA_W-1:0];
                            finish_reg  <= 1'b1;
                            state_reg   <= IDLE;
                        end
                    end
                    SCALE_MUL:
                    begin
                        // |c| * limit < 2^32, so the top bits are zero
                        drem_reg  <= product[LIMIT_W +: SUM_W];
                        dbits_reg <= product[LIMIT_W-1:0];
                        cnt_reg   <= DivLast;
                        state_reg <= SCALE_DIV;
                    end
                    SCALE_DIV:
                    begin
                        drem_reg  <= quot_bit ? SUM_W'(dsh - {1'b0, root_reg}) : SUM_W'(dsh);
                        dbits_reg <= quot_next;
                        cnt_reg   <= cnt_reg - 1'b1;
                        if (cnt_reg == '0)
                        begin
                            if (sel_y_reg)
                            begin
                                res_y_reg  <= quot_signed;
                                finish_reg <= 1'b1;
                                state_reg  <= IDLE;
                            end
                            else
                            begin
                                res_x_reg <= quot_signed;
                                sel_y_reg <= 1'b1;
                                state_reg <= SCALE_MUL;
                            end
                        end
                    end
                    default:
                    begin
                        state_reg <= IDLE;
                    end
                endcase
            end
        end
    end

    assign status.idle = (state_reg == IDLE) && !finish_reg;
    assign status.done = finish_reg && out_free;

    assign result.speed_x     = res_x_reg;
    assign result.speed_y     = res_y_reg;
    assign result.was_limited = limited_reg;

endmodule

// ===== rtl/velocity_accumulate_magnitude_clamp_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_accumulate_magnitude_clamp_unit
// Accumulates a 2D velocity, limits its magnitude to the programmed speed.
// ----------------------------------------------------------------------------
// Steps per beat: square x, square y, sum, square root, limit check; when
// clamped, a multiply and a divide for x, then a multiply and a divide for y.
// Throughput: one beat at a time; ready again the cycle after the result
// moves to the output register; the root and divide steps dominate.
// Reset: velocity cleared, speed_limit = 2.5 in the fixed-point scale.
// ----------------------------------------------------------------------------
module velocity_accumulate_magnitude_clamp_unit
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic        [vamc_pkg::LIMIT_W-1:0] cfg_wr_data,
    vamc_req_if.sink                            req,
    vamc_rsp_if.source                          rsp
);

    localparam int LIMIT_W = vamc_pkg::LIMIT_W;
    localparam int DATA_W  = vamc_pkg::DATA_W;
    localparam longint LimitRaw = longint'(5) << (FRAC_BITS - 1);
    localparam longint LimitMax = (longint'(1) << LIMIT_W) - 1;
    localparam logic [LIMIT_W-1:0] LimitReset =
        (LimitRaw > LimitMax) ? LIMIT_W'(LimitMax) : LIMIT_W'(LimitRaw);

    logic [LIMIT_W-1:0]     speed_limit_reg;
    logic                   rsp_valid_reg;
    vamc_pkg::vamc_result_t rsp_data_reg;
    vamc_pkg::vamc_status_t core_status;
    vamc_pkg::vamc_result_t core_result;
    logic                   out_free;
    logic                   start;

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = core_status.idle;
    assign start     = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg <= LimitReset;
        end
        else if (cfg_wr_en)
        begin
            speed_limit_reg <= cfg_wr_data;
        end
    end

    vamc_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .delta_x     (req.delta_x),
        .delta_y     (req.delta_y),
        .speed_limit (speed_limit_reg),
        .out_free    (out_free),
        .status      (core_status),
        .result      (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (core_status.done)
            begin
                rsp_valid_reg <= 1'b1;
                rsp_data_reg  <= core_result;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.speed_x     = rsp_data_reg.speed_x;
    assign rsp.speed_y     = rsp_data_reg.speed_y;
    assign rsp.was_limited = rsp_data_reg.was_limited;

    logic [DATA_W:0] abs_x, abs_y;

    assign abs_x = rsp.speed_x[DATA_W-1] ? (~{1'b1, rsp.speed_x} + 1'b1)
                                         : {1'b0, rsp.speed_x};
    assign abs_y = rsp.speed_y[DATA_W-1] ? (~{1'b1, rsp.speed_y} + 1'b1)
                                         : {1'b0, rsp.speed_y};

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        core_status.done |-> (!rsp_valid_reg || rsp.ready))
        else $error("result overwritten before it was taken");

    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("second beat accepted while busy");

    a_clamp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.was_limited) |->
        (abs_x <= {2'b00, speed_limit_reg}) && (abs_y <= {2'b00, speed_limit_reg}))
        else $error("clamped vector exceeds speed limit");

endmodule

// ===== tb/tb_velocity_accumulate_magnitude_clamp_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_velocity_accumulate_magnitude_clamp_unit
// Self-checking bench for the velocity accumulate / magnitude clamp unit.
// A short table of directed adjustments (field extremes, magnitude equal to
// the limit, zero limit, limit of 28672) is followed by random phases, each
// under its own speed limit. Every accepted adjustment is run through a
// bit-exact velocity model and each result beat is compared field by field.
// Both handshakes see random gaps, with some phases left gap-free.
// ----------------------------------------------------------------------------
module tb_velocity_accumulate_magnitude_clamp_unit;

    localparam int DATA_W  = vamc_pkg::DATA_W;
    localparam int LIMIT_W = vamc_pkg::LIMIT_W;
    localparam int ROOT_W  = vamc_pkg::ROOT_W;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 150;
    localparam int PLAN_LEN     = 24;
    localparam int DRAIN_CYCLES = 60;

    typedef enum {ROW_CFG, ROW_ITEM, ROW_KNOWN} row_kind_t;

    // ROW_CFG: a = speed limit. ROW_ITEM / ROW_KNOWN: a, b = delta x, y;
    // ROW_KNOWN also carries the result (ex, ey, el).
    typedef struct {
        row_kind_t kind;
        int        a;
        int        b;
        int        ex;
        int        ey;
        int        el;
    } plan_row_t;

    plan_row_t plan [PLAN_LEN] = '{
        '{ROW_KNOWN,      0,      0,      0, 0, 0},
        '{ROW_KNOWN,  10240,      0,  10240, 0, 0},
        '{ROW_KNOWN,      1,      0,  10240, 0, 1},
        '{ROW_KNOWN, -32768,      0, -10240, 0, 1},
        '{ROW_ITEM,       0, -32768,      0, 0, 0},
        '{ROW_ITEM,   32767,  32767,      0, 0, 0},
        '{ROW_ITEM,  -32768, -32768,      0, 0, 0},
        '{ROW_ITEM,      -1,     -1,      0, 0, 0},
        '{ROW_ITEM,   32767, -32768,      0, 0, 0},
        '{ROW_ITEM,       0,      0,      0, 0, 0},
        '{ROW_ITEM,  -32768,  32767,      0, 0, 0},
        '{ROW_CFG,        0,      0,      0, 0, 0},
        '{ROW_ITEM,       7,     -7,      0, 0, 0},
        '{ROW_KNOWN,      0,      0,      0, 0, 0},
        '{ROW_KNOWN, -32768,  32767,      0, 0, 1},
        '{ROW_KNOWN,      0,      0,      0, 0, 0},
        '{ROW_CFG,    28672,      0,      0, 0, 0},
        '{ROW_KNOWN,  32767,      0,  28672, 0, 1},
        '{ROW_ITEM,  -32768, -32768,      0, 0, 0},
        '{ROW_ITEM,       1,      1,      0, 0, 0},
        '{ROW_CFG,        1,      0,      0, 0, 0},
        '{ROW_ITEM,       3,      4,      0, 0, 0},
        '{ROW_ITEM,  -32768,      0,      0, 0, 0},
        '{ROW_ITEM,       0,      0,      0, 0, 0}
    };

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [LIMIT_W-1:0] cfg_wr_data;

    vamc_req_if req_ch ();
    vamc_rsp_if rsp_ch ();

    velocity_accumulate_magnitude_clamp_unit dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // model state
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic [LIMIT_W-1:0]       vel_limit;

    vamc_pkg::vamc_result_t pending_velocity [$];

    bit idle_on;
    int stall_left;
    int cycle_count;
    int mismatch_count;
    int beats_sent;
    int results_seen;
    int clamps_seen;
    int limit_writes;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic longint floor_root(input longint v);
        longint root;
        longint cand;
        root = 0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            cand = root | (longint'(1) << b);
            if (cand * cand <= v)
                root = cand;
        end
        return root;
    endfunction

    function automatic vamc_pkg::vamc_result_t advance_velocity(
        input logic signed [DATA_W-1:0] dx,
        input logic signed [DATA_W-1:0] dy);
        longint sum_x;
        longint sum_y;
        longint lim;
        longint mag;
        vamc_pkg::vamc_result_t res;
        sum_x = longint'(vel_x) + longint'(dx);
        sum_y = longint'(vel_y) + longint'(dy);
        lim   = longint'(vel_limit);
        mag   = floor_root(sum_x * sum_x + sum_y * sum_y);
        res.was_limited = 1'b0;
        if (mag > lim)
        begin
            sum_x = (sum_x * lim) / mag;
            sum_y = (sum_y * lim) / mag;
            res.was_limited = 1'b1;
        end
        vel_x = sum_x[DATA_W-1:0];
        vel_y = sum_y[DATA_W-1:0];
        res.speed_x = sum_x[DATA_W-1:0];
        res.speed_y = sum_y[DATA_W-1:0];
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_cycles();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(12, 60);
    endfunction

    task automatic push_adjustment(input logic signed [DATA_W-1:0] dx,
                                   input logic signed [DATA_W-1:0] dy,
                                   input bit known,
                                   input vamc_pkg::vamc_result_t want);
        int gap;
        vamc_pkg::vamc_result_t predicted;
        gap = idle_cycles();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.delta_x <= dx;
        req_ch.delta_y <= dy;
        do @(posedge clk); while (!req_ch.ready);
        predicted = advance_velocity(dx, dy);
        pending_velocity.push_back(known ? want : predicted);
        beats_sent++;
    endtask

    task automatic write_speed_limit(input logic [LIMIT_W-1:0] value);
        req_ch.valid <= 1'b0;
        while (pending_velocity.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        vel_limit = value;
        limit_writes++;
    endtask

    // result side back-pressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            stall_left = idle_cycles();
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_velocity.size());
            $display("tb_velocity_accumulate_magnitude_clamp_unit NOT OK");
            $finish;
        end
        else if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (pending_velocity.size() == 0)
            begin
                $error("result beat with nothing outstanding: x=%0d y=%0d lim=%0b",
                       rsp_ch.speed_x, rsp_ch.speed_y, rsp_ch.was_limited);
                mismatch_count++;
            end
            else
            begin
                vamc_pkg::vamc_result_t want;
                want = pending_velocity.pop_front();
                if (want.was_limited)
                    clamps_seen++;
                if (rsp_ch.speed_x !== want.speed_x)
                begin
                    $error("speed_x: expected %0d, got %0d", want.speed_x, rsp_ch.speed_x);
                    mismatch_count++;
                end
                if (rsp_ch.speed_y !== want.speed_y)
                begin
                    $error("speed_y: expected %0d, got %0d", want.speed_y, rsp_ch.speed_y);
                    mismatch_count++;
                end
                if (rsp_ch.was_limited !== want.was_limited)
                begin
                    $error("was_limited: expected %0b, got %0b",
                           want.was_limited, rsp_ch.was_limited);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        int dx;
        int dy;
        int span;
        int extremes [5];
        vamc_pkg::vamc_result_t want;
        logic [LIMIT_W-1:0] lim;

        extremes = '{-32768, -1, 0, 1, 32767};
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        req_ch.valid   = 1'b0;
        req_ch.delta_x = '0;
        req_ch.delta_y = '0;
        rsp_ch.ready   = 1'b0;
        stall_left     = 0;
        idle_on        = 1'b1;
        vel_x          = '0;
        vel_y          = '0;
        vel_limit      = LIMIT_W'(5 << 11);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_LEN; i++)
        begin
            case (plan[i].kind)
                ROW_CFG:
                begin
                    write_speed_limit(LIMIT_W'(plan[i].a));
                end
                ROW_ITEM:
                begin
                    push_adjustment(DATA_W'(plan[i].a), DATA_W'(plan[i].b), 1'b0, '0);
                end
                ROW_KNOWN:
                begin
                    want.speed_x     = DATA_W'(plan[i].ex);
                    want.speed_y     = DATA_W'(plan[i].ey);
                    want.was_limited = plan[i].el[0];
                    push_adjustment(DATA_W'(plan[i].a), DATA_W'(plan[i].b), 1'b1, want);
                end
            endcase
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: lim = LIMIT_W'(10240);
                1: lim = LIMIT_W'(0);
                2: lim = LIMIT_W'(28672);
                3: lim = LIMIT_W'(1);
                default: lim = LIMIT_W'($urandom_range(0, 28672));
            endcase
            write_speed_limit(lim);
            idle_on = !(ph == 2 || ph == 5);
            span = int'(lim) / 4 + 16;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2:
                    begin
                        dx = $urandom;
                        dy = $urandom;
                    end
                    3, 4, 5:
                    begin
                        dx = int'($urandom_range(0, 2 * span)) - span;
                        dy = int'($urandom_range(0, 2 * span)) - span;
                    end
                    6:
                    begin
                        dx = extremes[$urandom_range(0, 4)];
                        dy = extremes[$urandom_range(0, 4)];
                    end
                    7, 8:
                    begin
                        // pull the velocity back near the origin
                        dx = -int'(vel_x) + int'($urandom_range(0, 64)) - 32;
                        dy = -int'(vel_y) + int'($urandom_range(0, 64)) - 32;
                        dx = (dx > 32767) ? 32767 : ((dx < -32768) ? -32768 : dx);
                        dy = (dy > 32767) ? 32767 : ((dy < -32768) ? -32768 : dy);
                    end
                    default:
                    begin
                        dx = 0;
                        dy = 0;
                    end
                endcase
                push_adjustment(DATA_W'(dx), DATA_W'(dy), 1'b0, '0);
            end
        end

        req_ch.valid <= 1'b0;
        while (pending_velocity.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d adjustments over %0d speed limits, %0d results checked, %0d clamped",
                 beats_sent, limit_writes, results_seen, clamps_seen);
        if (mismatch_count == 0)
            $display("tb_velocity_accumulate_magnitude_clamp_unit OK");
        else
            $display("tb_velocity_accumulate_magnitude_clamp_unit NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/vamc_pkg.sv
rtl/vamc_req_if.sv
rtl/vamc_rsp_if.sv
rtl/vamc_core.sv
rtl/velocity_accumulate_magnitude_clamp_unit.sv
tb/tb_velocity_accumulate_magnitude_clamp_unit.sv
